### hw/rtl/pdsa_pkg.sv
// shared widths, payload types and status codes of the duty step adjuster
package pdsa_pkg;

  localparam int ERR_W  = 21;               // signed error field
  localparam int REF_W  = 20;               // reference level field
  localparam int DUTY_W = 17;               // duty, full scale and compare value
  localparam int MAG_W  = ERR_W;            // error magnitude, holds 2**(ERR_W-1)
  localparam int PROD_W = MAG_W + DUTY_W;   // magnitude times full scale
  localparam int QUO_W  = REF_W;            // quotient bits kept, saturating above
  localparam int CNT_W  = $clog2(QUO_W + 1);

  typedef logic [DUTY_W-1:0] duty_t;
  typedef logic [1:0]        status_t;

  localparam duty_t FULL_SCALE_RESET = duty_t'(78124);

  localparam status_t STATUS_OFF  = 2'd0;
  localparam status_t STATUS_FULL = 2'd1;
  localparam status_t STATUS_PART = 2'd2;

  typedef struct packed {
    logic signed [ERR_W-1:0] error_value;
    logic [REF_W-1:0]        reference_level;
  } in_word_t;

  typedef struct packed {
    duty_t   duty_now;
    duty_t   compare_value;
    logic    duty_changed;
    status_t duty_status;
  } out_word_t;

endpackage

### hw/rtl/pdsa_stream_if.sv
// valid/ready channel carrying one word of a given type
interface pdsa_stream_if #(
  parameter type word_t = logic
);
  logic  valid;
  logic  ready;
  word_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

### hw/rtl/pdsa_mul.sv
// bit-serial shift-add multiplier, one multiplier bit per cycle
module pdsa_mul (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start_i,
  input  logic [pdsa_pkg::MAG_W-1:0]   mcand_i,
  input  logic [pdsa_pkg::DUTY_W-1:0]  mplier_i,
  output logic [pdsa_pkg::PROD_W-1:0]  prod_o,
  output logic                         done_o
);
  import pdsa_pkg::*;

  logic [MAG_W-1:0]  hi_q, hi_d;
  logic [DUTY_W-1:0] lo_q, lo_d;
  logic [MAG_W-1:0]  mcand_q;
  logic [CNT_W-1:0]  cnt_q, cnt_d;
  logic              busy_q, busy_d;
  logic              done_q, done_d;
  logic [MAG_W:0]    sum;

  // partial sum of the upper half, multiplier bit gates the multiplicand
  assign sum = {1'b0, hi_q} + {1'b0, mcand_q & {MAG_W{lo_q[0]}}};

  always_comb begin
    hi_d   = hi_q;
    lo_d   = lo_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (start_i) begin
      hi_d   = '0;
      lo_d   = mplier_i;
      cnt_d  = '0;
      busy_d = 1'b1;
    end else if (busy_q) begin
      hi_d  = sum[MAG_W:1];
      lo_d  = {sum[0], lo_q[DUTY_W-1:1]};
      cnt_d = cnt_q + 1'b1;
      if (cnt_q == CNT_W'(DUTY_W - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    hi_q <= hi_d;
    lo_q <= lo_d;
    if (start_i) begin
      mcand_q <= mcand_i;
    end
  end

  assign prod_o = {hi_q, lo_q};
  assign done_o = done_q;

endmodule

### hw/rtl/pdsa_div.sv
// restoring divider, one quotient bit per cycle, saturating quotient
module pdsa_div (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start_i,
  input  logic [pdsa_pkg::PROD_W-1:0]  dividend_i,
  input  logic [pdsa_pkg::REF_W-1:0]   divisor_i,
  input  logic                         nonzero_i,
  output logic [pdsa_pkg::QUO_W-1:0]   quo_o,
  output logic                         done_o
);
  import pdsa_pkg::*;

  logic [REF_W-1:0]   rem_q, rem_d;
  logic [QUO_W-1:0]   quo_q, quo_d;
  logic [REF_W-1:0]   divisor_q;
  logic               sat_q, zero_q;
  logic [CNT_W-1:0]   cnt_q, cnt_d;
  logic               busy_q, busy_d;
  logic               done_q, done_d;
  logic [REF_W-1:0]   dvd_hi;
  logic               ovf;
  logic [REF_W:0]     trial;
  logic [REF_W+1:0]   diff;

  // upper dividend bits at or above the divisor mean the quotient overflows
  assign dvd_hi = REF_W'(dividend_i[PROD_W-1:QUO_W]);
  assign ovf    = (dvd_hi >= divisor_i);

  assign trial = {rem_q, quo_q[QUO_W-1]};
  assign diff  = {1'b0, trial} - {2'b00, divisor_q};

  always_comb begin
    rem_d  = rem_q;
    quo_d  = quo_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (start_i) begin
      rem_d  = dvd_hi;
      quo_d  = dividend_i[QUO_W-1:0];
      cnt_d  = '0;
      busy_d = 1'b1;
    end else if (busy_q) begin
      if (!diff[REF_W+1]) begin
        rem_d = diff[REF_W-1:0];
        quo_d = {quo_q[QUO_W-2:0], 1'b1};
      end else begin
        rem_d = trial[REF_W-1:0];
        quo_d = {quo_q[QUO_W-2:0], 1'b0};
      end
      cnt_d = cnt_q + 1'b1;
      if (cnt_q == CNT_W'(QUO_W - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
    if (start_i) begin
      divisor_q <= divisor_i;
      sat_q     <= ovf;
      zero_q    <= !nonzero_i;
    end
  end

  always_comb begin
    if (zero_q) begin
      quo_o = '0;
    end else if (sat_q) begin
      quo_o = '1;
    end else begin
      quo_o = quo_q;
    end
  end

  assign done_o = done_q;

endmodule

### hw/rtl/pwm_duty_step_adjuster.sv
// top level of the pwm duty step adjuster
// Each input word carries a signed error and a reference level; the block moves its
// stored duty by one step and returns one result word: the new duty, the timer
// compare value (full scale minus duty), a changed flag and a status (off, full,
// partial). The step is |error| * full_scale / reference, truncated, with the sign
// of the error: a positive error never steps by zero (minimum +1) and a step above
// half the duty is halved, rounding up; a zero or negative error steps by at least
// -1, and a step that reaches the duty is replaced by minus half the duty, rounded
// up. The new duty is clamped to 0..full_scale. A zero reference saturates the step.
// The block takes one word at a time: the result word is loaded into the output
// register and only then can the next word be taken. The multiply runs bit-serially
// over the 17 bits of full_scale, the product is handed to the divider, a restoring
// divider produces the 20 quotient bits (larger quotients saturate), the quotient
// leaves the divider and the step is applied. A result waits in the output register
// while the next word is accepted; a word whose step is ready holds in place until
// the output register frees up, and the block only holds off a new word while one
// is in flight. full_scale resets to 78124 and may be rewritten only while no word
// is in flight.
module pwm_duty_step_adjuster (
  input  logic          clk_i,
  input  logic          rst_ni,
  pdsa_stream_if.sink   in_i,
  pdsa_stream_if.source out_o,
  pdsa_stream_if.sink   cfg_i
);
  import pdsa_pkg::*;

  // one-hot sequencer
  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_MUL  = 4'b0010,
    S_DIV  = 4'b0100,
    S_UPD  = 4'b1000
  } state_e;

  state_e            state_q, state_d;
  duty_t             duty_q;
  duty_t             full_scale_q;
  logic [REF_W-1:0]  ref_q;
  logic              pos_q;         // error strictly positive
  logic              nz_q;          // error nonzero
  out_word_t         out_q;
  logic              out_valid_q;

  logic              in_accept;
  logic              out_load;
  logic signed [ERR_W-1:0] err;
  logic [MAG_W-1:0]  err_mag;
  logic              mul_done;
  logic [PROD_W-1:0] prod;
  logic              div_start;
  logic              div_done;
  logic [QUO_W-1:0]  quo;

  // step arithmetic
  logic [QUO_W:0]    pstep;
  logic [QUO_W+1:0]  psum;
  logic [QUO_W-1:0]  nmag;
  logic [DUTY_W:0]   duty_p1;
  duty_t             ndiff;
  duty_t             next_duty;
  status_t           next_status;

  assign err       = in_i.data.error_value;
  assign err_mag   = err[ERR_W-1] ? MAG_W'(-err) : MAG_W'(err);
  assign in_accept = in_i.valid && in_i.ready;
  assign in_i.ready = (state_q == S_IDLE);

  // config word is always taken; the user must make writes happen only while idle, the block does not enforce it
  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      full_scale_q <= FULL_SCALE_RESET;
    end else if (cfg_i.valid && cfg_i.ready) begin
      full_scale_q <= cfg_i.data;
    end
  end

  // capture what the later phases need
  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      ref_q <= in_i.data.reference_level;
      pos_q <= !err[ERR_W-1] && (err != '0);
      nz_q  <= (err != '0);
    end
  end

  pdsa_mul u_mul (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (in_accept),
    .mcand_i  (err_mag),
    .mplier_i (full_scale_q),
    .prod_o   (prod),
    .done_o   (mul_done)
  );

  assign div_start = (state_q == S_MUL) && mul_done;

  pdsa_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (prod),
    .divisor_i  (ref_q),
    .nonzero_i  (nz_q),
    .quo_o      (quo),
    .done_o     (div_done)
  );

  // apply the step to the duty
  always_comb begin
    pstep     = '0;
    psum      = '0;
    nmag      = '0;
    ndiff     = '0;
    duty_p1   = {1'b0, duty_q} + 1'b1;
    next_duty = duty_q;
    if (pos_q) begin
      // positive error: at least +1, halve a step above half the duty
      if (quo == '0) begin
        pstep = (QUO_W+1)'(1);
      end else if (quo > QUO_W'(duty_q[DUTY_W-1:1])) begin
        pstep = ({1'b0, quo} + 1'b1) >> 1;
      end else begin
        pstep = {1'b0, quo};
      end
      psum = (QUO_W+2)'(duty_q) + {1'b0, pstep};
      if (psum > (QUO_W+2)'(full_scale_q)) begin
        next_duty = full_scale_q;
      end else begin
        next_duty = psum[DUTY_W-1:0];
      end
    end else begin
      // zero or negative error: at least -1, a step that reaches the duty becomes half of it, rounded up
      if (quo == '0) begin
        nmag = QUO_W'(1);
      end else if (quo >= QUO_W'(duty_q)) begin
        nmag = QUO_W'(duty_p1[DUTY_W:1]);
      end else begin
        nmag = quo;
      end
      if (nmag > QUO_W'(duty_q)) begin
        next_duty = '0;
      end else begin
        ndiff = duty_q - nmag[DUTY_W-1:0];
        if (ndiff > full_scale_q) begin
          next_duty = full_scale_q;
        end else begin
          next_duty = ndiff;
        end
      end
    end
  end

  always_comb begin
    if (next_duty == '0) begin
      next_status = STATUS_OFF;
    end else if (next_duty == full_scale_q) begin
      next_status = STATUS_FULL;
    end else begin
      next_status = STATUS_PART;
    end
  end

  // result goes out once the output register is free
  assign out_load = (state_q == S_UPD) && (!out_valid_q || out_o.ready);

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (in_accept) begin
          state_d = S_MUL;
        end
      end
      S_MUL: begin
        if (mul_done) begin
          state_d = S_DIV;
        end
      end
      S_DIV: begin
        if (div_done) begin
          state_d = S_UPD;
        end
      end
      S_UPD: begin
        if (out_load) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      duty_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (out_load) begin
        duty_q      <= next_duty;
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_q.duty_now      <= next_duty;
      out_q.compare_value <= full_scale_q - next_duty;
      out_q.duty_changed  <= (next_duty != duty_q);
      out_q.duty_status   <= next_status;
    end
  end

  assign out_o.valid = out_valid_q;
  assign out_o.data  = out_q;

endmodule

### sim/pwm_duty_step_adjuster_test.sv
// self-checking testbench of the pwm duty step adjuster: directed and random words against a duty predictor
`timescale 1ns / 100ps

module pwm_duty_step_adjuster_test;
  import pdsa_pkg::*;

  localparam int     CLK_HALF     = 5;
  localparam int     RESET_CYCLES = 7;
  localparam int     TAIL_CYCLES  = 60;        // a bit more than one word of latency
  localparam int     PHASE_ITEMS  = 215;
  localparam longint STEP_HI      = 64'sd2147483647;
  localparam longint STEP_LO      = -64'sd2147483648;
  localparam longint ERR_HI       = 64'sd1048575;
  localparam longint ERR_LO       = -64'sd1048576;

  logic clk_i = 1'b0;
  logic rst_ni;

  pdsa_stream_if #(.word_t(in_word_t))  in_if  ();
  pdsa_stream_if #(.word_t(out_word_t)) out_if ();
  pdsa_stream_if #(.word_t(duty_t))     cfg_if ();

  pwm_duty_step_adjuster u_top (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .out_o  (out_if),
    .cfg_i  (cfg_if)
  );

  always #CLK_HALF clk_i = ~clk_i;

  // predictor state: our own copy of the duty and of the full scale register
  duty_t     duty_model;
  duty_t     scale_model;
  out_word_t duty_results_q[$];   // result words still owed by the block, oldest first
  out_word_t want_word;
  int        fail_count = 0;
  bit        calm = 1'b0;          // no idling on either side while set
  int        stall_left = 0;

  // mostly short gaps, now and then a long one
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 90) return $urandom_range(1, 5);
    return $urandom_range(10, 80);
  endfunction

  // works out the result word of one accepted word and advances the duty
  function automatic out_word_t predict_duty_step(in_word_t w);
    longint    err, lvl, duty, step, nxt, mag;
    out_word_t r;
    err  = $signed(w.error_value);
    lvl  = longint'(w.reference_level);
    duty = longint'(duty_model);
    // raw step, truncated toward zero; a zero reference saturates by sign
    if (lvl == 0) begin
      step = (err > 0) ? STEP_HI : (err < 0) ? STEP_LO : 0;
    end else begin
      step = (err * longint'(scale_model)) / lvl;
      if (step > STEP_HI) step = STEP_HI;
      if (step < STEP_LO) step = STEP_LO;
    end
    if (err > 0) begin
      // never a zero step, and a big step is halved rounding up
      if (step == 0) step = 1;
      else if (step > duty / 2) step = (step + 1) / 2;
    end else begin
      // zero error goes this way too and steps down by one
      mag = (step < 0) ? -step : step;
      if (step == 0) step = -1;
      else if (mag >= duty) step = -((duty + 1) / 2);
    end
    nxt = duty + step;
    if (nxt > longint'(scale_model)) nxt = longint'(scale_model);
    else if (nxt < 0) nxt = 0;
    r.duty_changed = (nxt != duty);
    if (r.duty_changed) duty_model = duty_t'(nxt);
    if (duty_model == '0) r.duty_status = STATUS_OFF;
    else if (duty_model == scale_model) r.duty_status = STATUS_FULL;
    else r.duty_status = STATUS_PART;
    r.duty_now      = duty_model;
    r.compare_value = duty_t'(scale_model - duty_model);
    return r;
  endfunction

  task automatic report_mismatch(input string what, input longint got, input longint want);
    $display("mismatch %s: got %0d, want %0d at %0t", what, got, want, $time);
    fail_count++;
  endtask

  // sends one word; valid stays high afterwards so back-to-back words need no dip
  task automatic send_word(input longint err, input longint lvl);
    in_word_t w;
    int       gap;
    w.error_value     = ERR_W'(err);
    w.reference_level = REF_W'(lvl);
    gap = calm ? 0 : pick_gap();
    if (gap > 0) begin
      @(negedge clk_i);
      in_if.valid <= 1'b0;
      repeat (gap - 1) @(negedge clk_i);
    end
    @(negedge clk_i);
    in_if.data  <= w;
    in_if.valid <= 1'b1;
    do @(posedge clk_i); while (!in_if.ready);
    duty_results_q.push_back(predict_duty_step(w));
  endtask

  // drops valid and waits until every owed result word has come back
  task automatic wait_drain();
    @(negedge clk_i);
    in_if.valid <= 1'b0;
    while (duty_results_q.size() != 0) @(posedge clk_i);
  endtask

  // full scale may only change with nothing in flight
  task automatic write_full_scale(input duty_t value);
    wait_drain();
    @(negedge clk_i);
    cfg_if.data  <= value;
    cfg_if.valid <= 1'b1;
    do @(posedge clk_i); while (!cfg_if.ready);
    scale_model = value;
    @(negedge clk_i);
    cfg_if.valid <= 1'b0;
  endtask

  // random word: mostly errors scaled to the reference so steps land near the duty,
  // some raw bit patterns and field extremes, now and then a zero reference
  task automatic send_random_word();
    longint lvl, err, bound;
    int     mode;
    mode = $urandom_range(0, 19);
    if (mode == 0) lvl = 0;
    else if (mode < 4) lvl = longint'(REF_W'($urandom));
    else lvl = $urandom_range(1, 1000000);
    mode = $urandom_range(0, 9);
    if (mode == 0) begin
      err = $signed(ERR_W'($urandom));
    end else if (mode == 1) begin
      case ($urandom_range(0, 4))
        0: err = ERR_HI;
        1: err = ERR_LO;
        2: err = 0;
        3: err = 1;
        default: err = -1;
      endcase
    end else begin
      bound = (lvl >> $urandom_range(0, 14)) + 1;
      err   = longint'($urandom_range(0, int'(2 * bound))) - bound;
      if (err > ERR_HI) err = ERR_HI;
      if (err < ERR_LO) err = ERR_LO;
    end
    send_word(err, lvl);
  endtask

  // ready side: random stalls unless a calm stretch runs
  always @(negedge clk_i) begin
    if (!rst_ni || calm) begin
      out_if.ready <= rst_ni;
    end else if (stall_left > 0) begin
      out_if.ready <= 1'b0;
      stall_left   <= stall_left - 1;
    end else begin
      out_if.ready <= 1'b1;
      if ($urandom_range(0, 9) < 3) stall_left <= pick_gap();
    end
  end

  // every accepted result word is held against the oldest prediction
  always @(posedge clk_i) begin
    if (rst_ni && out_if.valid && out_if.ready) begin
      if (duty_results_q.size() == 0) begin
        report_mismatch("result word with none owed", longint'(out_if.data.duty_now), -1);
      end else begin
        want_word = duty_results_q.pop_front();
        if (out_if.data.duty_now != want_word.duty_now)
          report_mismatch("duty_now", out_if.data.duty_now, want_word.duty_now);
        if (out_if.data.compare_value != want_word.compare_value)
          report_mismatch("compare_value", out_if.data.compare_value, want_word.compare_value);
        if (out_if.data.duty_changed != want_word.duty_changed)
          report_mismatch("duty_changed", out_if.data.duty_changed, want_word.duty_changed);
        if (out_if.data.duty_status != want_word.duty_status)
          report_mismatch("duty_status", out_if.data.duty_status, want_word.duty_status);
      end
    end
  end

  // reset scale: zero error at zero duty, tiny positive step, halving, zero reference
  task automatic test_reset_scale();
    send_word(0, 1000);
    send_word(1, 1000000);
    send_word(1000, 1000);
    send_word(-1, 1000000);
    send_word(1000000, 1);
    send_word(ERR_LO, 0);
    send_word(ERR_HI, 0);
    send_word(0, 0);
  endtask

  // field extremes at the largest full scale
  task automatic test_field_extremes();
    write_full_scale(duty_t'(131071));
    send_word(ERR_HI, 1048575);
    send_word(ERR_LO, 1048575);
    send_word(ERR_HI, 1);
    send_word(ERR_HI, 1);
    send_word(ERR_LO, 1);
    send_word(0, 1048575);
    send_word(1, 0);
    send_word(-1, 0);
  endtask

  // full scale lowered under the duty: the clamp must pull the duty down
  task automatic test_scale_drop();
    write_full_scale(duty_t'(131071));
    send_word(1000, 1);
    send_word(1000, 1);
    send_word(1000, 1);
    write_full_scale(duty_t'(1000));
    send_word(1, 1000000);
    send_word(1, 1);
    send_word(-3, 7);
  endtask

  // full scale of zero keeps the duty off whatever comes in
  task automatic test_scale_zero();
    write_full_scale(duty_t'(0));
    send_word(5, 10);
    send_word(-5, 10);
    send_word(ERR_HI, 0);
  endtask

  task automatic test_random_phase(input duty_t scale, input int count, input bit quiet,
                                   input bit hold_off);
    write_full_scale(scale);
    calm = quiet;
    for (int i = 0; i < count; i++) begin
      // sender holds off once until every owed word is back
      if (hold_off && i == count / 2) wait_drain();
      send_random_word();
    end
    calm = 1'b0;
  endtask

  initial begin
    in_if.valid  = 1'b0;
    in_if.data   = '0;
    cfg_if.valid = 1'b0;
    cfg_if.data  = '0;
    out_if.ready = 1'b0;
    rst_ni       = 1'b0;
    duty_model   = '0;
    scale_model  = FULL_SCALE_RESET;
    repeat (RESET_CYCLES) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    test_reset_scale();
    test_field_extremes();
    test_scale_drop();
    test_scale_zero();
    test_random_phase(duty_t'(1), PHASE_ITEMS, 1'b0, 1'b1);
    test_random_phase(duty_t'(131071), PHASE_ITEMS, 1'b0, 1'b0);
    test_random_phase(FULL_SCALE_RESET, PHASE_ITEMS, 1'b1, 1'b0);
    test_random_phase(duty_t'($urandom_range(2, 131070)), PHASE_ITEMS, 1'b0, 1'b0);
    test_random_phase(duty_t'($urandom_range(2, 300)), PHASE_ITEMS, 1'b0, 1'b1);

    wait_drain();
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  // watchdog, far beyond the slowest legal run
  initial begin
    #10_000_000;
    $display("Verification failed");
    $finish;
  end

endmodule
